// ===== src/ehla_pkg.sv =====
// Shared types and constants for the event Hough line accumulator.
package ehla_pkg;

  typedef enum logic [3:0] {
    ST_INIT_MUL,
    ST_INIT_WR,
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SCALE,
    ST_RHO,
    ST_READ,
    ST_DECAY,
    ST_VOTE,
    ST_WRITE,
    ST_ZONE,
    ST_DONE
  } state_e;

  // register indexes on the config port
  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_TRACKING   = 3'd1;
  localparam logic [2:0] REG_ZONE_THETA = 3'd2;
  localparam logic [2:0] REG_ZONE_RHO   = 3'd3;
  localparam logic [2:0] REG_CENTER_X   = 3'd4;
  localparam logic [2:0] REG_CENTER_Y   = 3'd5;
  localparam logic [2:0] REG_RHO_SCALE  = 3'd6;

  typedef struct packed {
    logic [15:0] threshold;
    logic        tracking;
    logic [2:0]  zone_theta;
    logic [2:0]  zone_rho;
    logic [9:0]  center_x;
    logic [9:0]  center_y;
    logic [15:0] rho_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    threshold:  16'd2560,
    tracking:   1'b0,
    zone_theta: 3'd1,
    zone_rho:   3'd1,
    center_x:   10'd152,
    center_y:   10'd120,
    rho_scale:  16'd13107
  };

  // results reported per event at most
  localparam int unsigned MAX_OUT = 64;
  localparam int unsigned CNT_W   = 7;

  // 2^32 minus exp(-2e-4) in Q0.32
  localparam logic [19:0] STEP_DEFICIT = 20'd858908;
  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam longint      ONE_Q30      = 64'sd1073741824;

endpackage

// ===== src/event_hough_line_accumulator.sv =====
// Event Hough line accumulator: top level with sequencer, trig table and stores.
// Per event: each theta bin steps through MUL_X, MUL_Y, SCALE and RHO; a vote adds
//   READ, DECAY, VOTE and WRITE; in tracking mode a detection adds a zone clear of
//   (2*zone_theta+1)*(2*zone_rho+1) cells, then DONE ends the event. A found line is
//   held until another is found or the event ends; the last shows as busy_o drops.
// Throughput: one event at a time, taken while idle, on one shared trig multiplier.
// Reset: a pass over max(THETA_BINS*RHO_BINS, DECAY_RANGE) entries builds the decay
//   table and clears the stores; busy_o is high meanwhile, config writes still work.
// Results cannot be stalled: each is a one-cycle strobe on result_valid_o.
module event_hough_line_accumulator
  import ehla_pkg::*;
#(
  parameter int unsigned THETA_BINS  = 64,
  parameter int unsigned RHO_BINS    = 64,
  parameter int unsigned DECAY_RANGE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [9:0]  pixel_x_i,
  input  logic [9:0]  pixel_y_i,
  input  logic [31:0] event_time_i,
  output logic        result_valid_o,
  output logic        line_found_o,
  output logic [5:0]  theta_bin_o,
  output logic [5:0]  rho_bin_o,
  output logic        is_last_o
);

  localparam int unsigned NCELLS = THETA_BINS * RHO_BINS;
  localparam int unsigned NINIT  = (NCELLS > DECAY_RANGE) ? NCELLS : DECAY_RANGE;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned THW    = $clog2(THETA_BINS);
  localparam int unsigned RW     = $clog2(RHO_BINS);
  localparam int unsigned DW     = $clog2(DECAY_RANGE);
  localparam int unsigned IW     = $clog2(NINIT) + 1;

  // ---------------------------------------------------------------------------
  // cos/sin table in Q1.14, built at elaboration from a Taylor series
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] trig_entry(int unsigned k, bit want_sin);
    int unsigned q;
    int unsigned r;
    logic [63:0] phi;
    logic [63:0] x2;
    logic [63:0] t;
    longint      ss;
    longint      cs;
    longint      c;
    longint      s;
    longint      cc;
    longint      sc;
    longint      res;
    phi = 64'd0;
    q   = (4 * k) / THETA_BINS;
    r   = (4 * k) % THETA_BINS;
    phi = (64'(r) * HALF_PI_Q30) / THETA_BINS;
    x2  = (phi * phi) >> 30;
    t   = phi;
    ss  = longint'(phi);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x2) >> 30;
      case (n)
        1: t = t / 6;
        2: t = t / 20;
        3: t = t / 42;
        4: t = t / 72;
        5: t = t / 110;
        6: t = t / 156;
        default: t = t / 210;
      endcase
      ss = (n % 2 == 1) ? ss - longint'(t) : ss + longint'(t);
    end
    t  = 64'(ONE_Q30);
    cs = ONE_Q30;
    for (int n = 1; n <= 7; n++) begin
      t = (t * x2) >> 30;
      case (n)
        1: t = t / 2;
        2: t = t / 12;
        3: t = t / 30;
        4: t = t / 56;
        5: t = t / 90;
        6: t = t / 132;
        default: t = t / 182;
      endcase
      cs = (n % 2 == 1) ? cs - longint'(t) : cs + longint'(t);
    end
    cc = (cs < 0) ? 0 : ((cs > ONE_Q30) ? ONE_Q30 : cs);
    sc = (ss < 0) ? 0 : ((ss > ONE_Q30) ? ONE_Q30 : ss);
    c  = (cc + 32768) >>> 16;
    s  = (sc + 32768) >>> 16;
    case (q % 4)
      0: res = want_sin ? s  : c;
      1: res = want_sin ? c  : -s;
      2: res = want_sin ? -s : -c;
      default: res = want_sin ? -c : s;
    endcase
    return 16'(res);
  endfunction

  logic signed [15:0] cos_tab [THETA_BINS];
  logic signed [15:0] sin_tab [THETA_BINS];

  for (genvar g = 0; g < THETA_BINS; g++) begin : g_trig
    localparam logic signed [15:0] COS_V = trig_entry(g, 1'b0);
    localparam logic signed [15:0] SIN_V = trig_entry(g, 1'b1);
    assign cos_tab[g] = COS_V;
    assign sin_tab[g] = SIN_V;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  cfg_t   cfg_q, cfg_d;

  logic [IW-1:0]      init_cnt_q, init_cnt_d;
  logic [32:0]        v_q, v_d;          // decay table recursion value, Q1.32
  logic [52:0]        ip_q, ip_d;        // v times step deficit

  logic signed [10:0] dx_q, dx_d;
  logic signed [10:0] dy_q, dy_d;
  logic [31:0]        now_q, now_d;
  logic [THW-1:0]     th_q, th_d;
  logic signed [26:0] prodx_q, prodx_d;
  logic signed [27:0] sum_q, sum_d;
  logic signed [45:0] prod_q, prod_d;
  logic [RW-1:0]      rho_q, rho_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               big_q, big_d;      // dt past the decay table
  logic [15:0]        acc_new_q, acc_new_d;
  logic               det_q, det_d;

  logic [THW-1:0]     tt_q, tt_d;        // zone theta bin
  logic signed [10:0] rr_q, rr_d;        // zone rho bin, before mirroring
  logic [3:0]         zi_q, zi_d;
  logic [3:0]         zj_q, zj_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic               pend_v_q, pend_v_d;
  logic [THW-1:0]     pend_th_q, pend_th_d;
  logic [RW-1:0]      pend_rho_q, pend_rho_d;

  logic               res_v_q, res_v_d;
  logic               res_found_q, res_found_d;
  logic [5:0]         res_th_q, res_th_d;
  logic [5:0]         res_rho_q, res_rho_d;
  logic               res_last_q, res_last_d;

  // stores
  logic [15:0] acc_mem  [NCELLS];
  logic [31:0] time_mem [NCELLS];
  logic [16:0] rom_mem  [DECAY_RANGE];
  logic [15:0] acc_rd_q;
  logic [31:0] time_rd_q;
  logic [16:0] rom_q;

  logic          acc_we;
  logic [AW-1:0] acc_waddr;
  logic [15:0]   acc_wdata;
  logic          time_we;
  logic [AW-1:0] time_waddr;
  logic [31:0]   time_wdata;
  logic          rom_we;
  logic [DW-1:0] rom_waddr;
  logic [16:0]   rom_wdata;
  logic [DW-1:0] rom_raddr;

  // datapath temporaries
  logic signed [10:0] trig_a;            // shared trig multiplier operands
  logic signed [15:0] trig_b;
  logic signed [26:0] trig_p;
  logic [45:0]        rho_rnd;
  logic [14:0]        rho_w;
  logic               rho_ok;
  logic [31:0]        dt;
  logic [32:0]        mul_v;
  logic [33:0]        mul_rnd;
  logic [17:0]        acc_sum;
  logic [64:0]        v_next;
  logic [33:0]        v_rnd;
  logic signed [10:0] ts;
  logic signed [10:0] rabs;
  logic               th_last;
  logic [15:0]        pth_ext;
  logic [15:0]        prho_ext;

  assign busy_o = (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    cfg_d       = cfg_q;
    init_cnt_d  = init_cnt_q;
    v_d         = v_q;
    ip_d        = ip_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    now_d       = now_q;
    th_d        = th_q;
    prodx_d     = prodx_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    rho_d       = rho_q;
    addr_d      = addr_q;
    big_d       = big_q;
    acc_new_d   = acc_new_q;
    det_d       = det_q;
    tt_d        = tt_q;
    rr_d        = rr_q;
    zi_d        = zi_q;
    zj_d        = zj_q;
    count_d     = count_q;
    pend_v_d    = pend_v_q;
    pend_th_d   = pend_th_q;
    pend_rho_d  = pend_rho_q;
    res_v_d     = 1'b0;
    res_found_d = res_found_q;
    res_th_d    = res_th_q;
    res_rho_d   = res_rho_q;
    res_last_d  = res_last_q;

    acc_we     = 1'b0;
    acc_waddr  = addr_q;
    acc_wdata  = 16'd0;
    time_we    = 1'b0;
    time_waddr = addr_q;
    time_wdata = now_q;
    rom_we     = 1'b0;
    rom_waddr  = init_cnt_q[DW-1:0];
    rom_wdata  = 17'd0;

    // one multiplier serves dx*cos and dy*sin on consecutive cycles
    trig_a  = (state_q == ST_MUL_Y) ? dy_q : dx_q;
    trig_b  = (state_q == ST_MUL_Y) ? sin_tab[th_q] : cos_tab[th_q];
    trig_p  = trig_a * trig_b;
    rho_rnd = prod_q + 46'sd536870912;
    rho_w   = rho_rnd[44:30];
    rho_ok  = !prod_q[45] && (prod_q != '0) && (rho_w != 15'd0) &&
              (rho_w < 15'(RHO_BINS));
    dt      = now_q - time_rd_q;
    rom_raddr = dt[DW-1:0];
    mul_v   = acc_rd_q * rom_q;
    mul_rnd = 34'(mul_v) + 34'd32768;
    acc_sum = big_q ? 18'd256 : (18'(mul_rnd[33:16]) + 18'd256);
    v_next  = {v_q, 32'd0} + 65'h0_8000_0000 - 65'(ip_q);
    v_rnd   = 34'(v_q) + 34'd32768;
    ts      = $signed(11'(th_q)) - $signed(11'(cfg_q.zone_theta));
    if (ts < 0) ts = ts + $signed(11'(THETA_BINS));
    if (ts < 0) ts = ts + $signed(11'(THETA_BINS));
    rabs    = (rr_q < 0) ? -rr_q : rr_q;
    th_last = (th_q == THW'(THETA_BINS - 1));
    pth_ext = 16'(pend_th_q);
    prho_ext = 16'(pend_rho_q);

    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD:  cfg_d.threshold  = cfg_data_i;
        REG_TRACKING:   cfg_d.tracking   = cfg_data_i[0];
        REG_ZONE_THETA: cfg_d.zone_theta = cfg_data_i[2:0];
        REG_ZONE_RHO:   cfg_d.zone_rho   = cfg_data_i[2:0];
        REG_CENTER_X:   cfg_d.center_x   = cfg_data_i[9:0];
        REG_CENTER_Y:   cfg_d.center_y   = cfg_data_i[9:0];
        REG_RHO_SCALE:  cfg_d.rho_scale  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_INIT_MUL: begin
        ip_d    = v_q * STEP_DEFICIT;
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        if (init_cnt_q < IW'(DECAY_RANGE)) begin
          rom_we    = 1'b1;
          rom_wdata = v_rnd[32:16];
        end
        if (init_cnt_q < IW'(NCELLS)) begin
          acc_we     = 1'b1;
          acc_waddr  = init_cnt_q[AW-1:0];
          time_we    = 1'b1;
          time_waddr = init_cnt_q[AW-1:0];
          time_wdata = 32'd0;
        end
        v_d = v_next[64:32];
        if (init_cnt_q == IW'(NINIT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          init_cnt_d = init_cnt_q + IW'(1);
          state_d    = ST_INIT_MUL;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          dx_d     = $signed({1'b0, pixel_x_i}) - $signed({1'b0, cfg_q.center_x});
          dy_d     = $signed({1'b0, pixel_y_i}) - $signed({1'b0, cfg_q.center_y});
          now_d    = event_time_i;
          th_d     = '0;
          count_d  = '0;
          pend_v_d = 1'b0;
          state_d  = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        prodx_d = trig_p;
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        sum_d   = prodx_q + trig_p;
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        prod_d  = sum_q * $signed({1'b0, cfg_q.rho_scale});
        state_d = ST_RHO;
      end
      ST_RHO: begin
        rho_d  = rho_w[RW-1:0];
        addr_d = AW'(th_q) * AW'(RHO_BINS) + AW'(rho_w[RW-1:0]);
        if (rho_ok) begin
          state_d = ST_READ;
        end else if (th_last) begin
          state_d = ST_DONE;
        end else begin
          th_d    = th_q + THW'(1);
          state_d = ST_MUL_X;
        end
      end
      ST_READ: begin
        // store read data lands at the end of this cycle
        state_d = ST_DECAY;
      end
      ST_DECAY: begin
        big_d   = (dt >= 32'(DECAY_RANGE));
        state_d = ST_VOTE;
      end
      ST_VOTE: begin
        acc_new_d = acc_sum[17:16] != 2'd0 ? 16'hFFFF : acc_sum[15:0];
        det_d     = (((acc_sum[17:16] != 2'd0) ? 16'hFFFF : acc_sum[15:0]) >=
                     cfg_q.threshold);
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        acc_we    = 1'b1;
        acc_wdata = det_q ? 16'd0 : acc_new_q;
        time_we   = 1'b1;
        if (det_q && (count_q < CNT_W'(MAX_OUT))) begin
          if (pend_v_q) begin
            res_v_d     = 1'b1;
            res_found_d = 1'b1;
            res_th_d    = pth_ext[5:0];
            res_rho_d   = prho_ext[5:0];
            res_last_d  = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_th_d  = th_q;
          pend_rho_d = rho_q;
          count_d    = count_q + CNT_W'(1);
        end
        if (det_q && cfg_q.tracking) begin
          tt_d    = ts[THW-1:0];
          rr_d    = $signed(11'(rho_q)) - $signed(11'(cfg_q.zone_rho));
          zi_d    = '0;
          zj_d    = '0;
          state_d = ST_ZONE;
        end else if (th_last) begin
          state_d = ST_DONE;
        end else begin
          th_d    = th_q + THW'(1);
          state_d = ST_MUL_X;
        end
      end
      ST_ZONE: begin
        if (rabs < $signed(11'(RHO_BINS))) begin
          acc_we    = 1'b1;
          acc_waddr = AW'(tt_q) * AW'(RHO_BINS) + AW'(rabs[RW-1:0]);
        end
        if (zj_q == {cfg_q.zone_rho, 1'b0}) begin
          zj_d = '0;
          rr_d = $signed(11'(rho_q)) - $signed(11'(cfg_q.zone_rho));
          if (zi_q == {cfg_q.zone_theta, 1'b0}) begin
            if (th_last) begin
              state_d = ST_DONE;
            end else begin
              th_d    = th_q + THW'(1);
              state_d = ST_MUL_X;
            end
          end else begin
            zi_d = zi_q + 4'd1;
            tt_d = (tt_q == THW'(THETA_BINS - 1)) ? '0 : tt_q + THW'(1);
          end
        end else begin
          zj_d = zj_q + 4'd1;
          rr_d = rr_q + 11'sd1;
        end
      end
      ST_DONE: begin
        res_v_d     = 1'b1;
        res_last_d  = 1'b1;
        res_found_d = pend_v_q;
        res_th_d    = pend_v_q ? pth_ext[5:0] : 6'd0;
        res_rho_d   = pend_v_q ? prho_ext[5:0] : 6'd0;
        pend_v_d    = 1'b0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_MUL;
      cfg_q       <= CFG_RESET;
      init_cnt_q  <= '0;
      v_q         <= 33'h1_0000_0000;
      count_q     <= '0;
      pend_v_q    <= 1'b0;
      res_v_q     <= 1'b0;
      th_q        <= '0;
      tt_q        <= '0;
      zi_q        <= '0;
      zj_q        <= '0;
    end else begin
      state_q     <= state_d;
      cfg_q       <= cfg_d;
      init_cnt_q  <= init_cnt_d;
      v_q         <= v_d;
      count_q     <= count_d;
      pend_v_q    <= pend_v_d;
      res_v_q     <= res_v_d;
      th_q        <= th_d;
      tt_q        <= tt_d;
      zi_q        <= zi_d;
      zj_q        <= zj_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ip_q        <= ip_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    now_q       <= now_d;
    prodx_q     <= prodx_d;
    sum_q       <= sum_d;
    prod_q      <= prod_d;
    rho_q       <= rho_d;
    addr_q      <= addr_d;
    big_q       <= big_d;
    acc_new_q   <= acc_new_d;
    det_q       <= det_d;
    rr_q        <= rr_d;
    pend_th_q   <= pend_th_d;
    pend_rho_q  <= pend_rho_d;
    res_found_q <= res_found_d;
    res_th_q    <= res_th_d;
    res_rho_q   <= res_rho_d;
    res_last_q  <= res_last_d;
  end

  // stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_q <= acc_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (time_we) time_mem[time_waddr] <= time_wdata;
    time_rd_q <= time_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[rom_waddr] <= rom_wdata;
    rom_q <= rom_mem[rom_raddr];
  end

  assign result_valid_o = res_v_q;
  assign line_found_o   = res_found_q;
  assign theta_bin_o    = res_th_q;
  assign rho_bin_o      = res_rho_q;
  assign is_last_o      = res_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_ends_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && res_last_q) |-> (state_q == ST_IDLE))
    else $error("final result while event still in work");

  a_nohit_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !res_found_q) |-> res_last_q)
    else $error("no-hit result not marked last");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_OUT))
    else $error("result count past cap");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted event did not raise busy");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the event Hough line accumulator.
`timescale 1ns / 1ps

module testbench;
  import ehla_pkg::*;

  localparam int unsigned N_THETA   = 64;
  localparam int unsigned N_RHO     = 64;
  localparam int unsigned DECAY_LEN = 32768;
  // 2^32 * exp(-2e-4), per-step decay factor
  localparam longint unsigned DECAY_STEP = 64'd4294108388;

  typedef struct packed {
    logic       found;
    logic [5:0] theta;
    logic [5:0] rho;
    logic       last;
  } line_res_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [2:0]  cfg_idx_i      = REG_THRESHOLD;
  logic [15:0] cfg_data_i     = '0;
  logic        start_i        = 1'b0;
  logic [9:0]  pixel_x_i      = '0;
  logic [9:0]  pixel_y_i      = '0;
  logic [31:0] event_time_i   = '0;
  logic        busy_o;
  logic        result_valid_o;
  logic        line_found_o;
  logic [5:0]  theta_bin_o;
  logic [5:0]  rho_bin_o;
  logic        is_last_o;

  event_hough_line_accumulator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .pixel_x_i, .pixel_y_i, .event_time_i, .result_valid_o, .line_found_o,
    .theta_bin_o, .rho_bin_o, .is_last_o
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the config, the stores and the tables
  // ---------------------------------------------------------------------------
  cfg_t         cfg_m;
  bit [15:0]    acc_m   [N_THETA*N_RHO];
  bit [31:0]    stamp_m [N_THETA*N_RHO];
  int unsigned  decay_rom [DECAY_LEN];
  int           cos_t [N_THETA];
  int           sin_t [N_THETA];

  line_res_t    line_q[$];       // lines still due from the block
  int unsigned  mismatch_cnt = 0;
  bit [31:0]    now_t = '0;      // running event time for the random part
  int unsigned  gap_pct = 0;     // sender idle chance, percent

  function automatic int q30_to_q14(longint s);
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    return int'((s + 32768) >>> 16);
  endfunction

  // Decay ROM and Q1.14 trig table, built the way the hardware defines them
  function automatic void build_tables();
    longint unsigned v, phi, x2, t;
    longint ss, cs;
    int c, s;
    int unsigned q, r;
    v = 64'd1 << 32;
    decay_rom[0] = 65536;
    for (int i = 1; i < DECAY_LEN; i++) begin
      v = (v * DECAY_STEP + (64'd1 << 31)) >> 32;
      decay_rom[i] = int'((v + 32768) >> 16);
    end
    for (int i = 0; i < N_THETA; i++) begin
      q   = (4 * i) / N_THETA;
      r   = (4 * i) % N_THETA;
      phi = (longint'(r) * HALF_PI_Q30) / N_THETA;
      x2  = (phi * phi) >> 30;
      // Taylor series, each term from the previous one
      t  = phi;
      ss = longint'(phi);
      for (int n = 1; n <= 7; n++) begin
        t  = ((t * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        ss = (n % 2) ? ss - longint'(t) : ss + longint'(t);
      end
      t  = ONE_Q30;
      cs = ONE_Q30;
      for (int n = 1; n <= 7; n++) begin
        t  = ((t * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        cs = (n % 2) ? cs - longint'(t) : cs + longint'(t);
      end
      c = q30_to_q14(cs);
      s = q30_to_q14(ss);
      case (q % 4)
        0: begin cos_t[i] = c;  sin_t[i] = s;  end
        1: begin cos_t[i] = -s; sin_t[i] = c;  end
        2: begin cos_t[i] = -c; sin_t[i] = -s; end
        default: begin cos_t[i] = s; sin_t[i] = -c; end
      endcase
    end
  endfunction

  // Clear a zone around a detection: theta wraps, rho mirrors at zero
  function automatic void clear_zone(int th, int rho);
    int tt, rr;
    for (int i = -int'(cfg_m.zone_theta); i <= int'(cfg_m.zone_theta); i++) begin
      tt = (th + i + N_THETA) % N_THETA;
      for (int j = -int'(cfg_m.zone_rho); j <= int'(cfg_m.zone_rho); j++) begin
        rr = rho + j;
        if (rr < 0) rr = -rr;
        if (rr < N_RHO) acc_m[tt * N_RHO + rr] = '0;
      end
    end
  endfunction

  // One event votes in each theta bin with rho in range; queue its lines
  function automatic void vote_event(bit [9:0] px, bit [9:0] py, bit [31:0] ts);
    longint dx, dy, prod, acc;
    longint unsigned rho;
    bit [31:0] dt;
    int bin_idx, hits;
    line_res_t res;
    dx   = longint'(px) - longint'(cfg_m.center_x);
    dy   = longint'(py) - longint'(cfg_m.center_y);
    hits = 0;
    for (int th = 0; th < N_THETA; th++) begin
      prod = (dx * cos_t[th] + dy * sin_t[th]) * longint'(cfg_m.rho_scale);
      if (prod <= 0) continue;
      rho = (longint'(prod) + (64'sd1 << 29)) >>> 30;
      if (rho == 0 || rho >= N_RHO) continue;
      bin_idx = th * N_RHO + int'(rho);
      dt   = ts - stamp_m[bin_idx];
      acc  = (dt >= DECAY_LEN) ? 0 :
             ((longint'(acc_m[bin_idx]) * decay_rom[dt] + 32768) >>> 16);
      acc  = acc + 256;
      if (acc > 65535) acc = 65535;
      acc_m[bin_idx] = acc[15:0];
      if (acc >= cfg_m.threshold) begin
        if (cfg_m.tracking) clear_zone(th, int'(rho));
        else acc_m[bin_idx] = '0;
        if (hits < MAX_OUT) begin
          res = '{found: 1'b1, theta: th[5:0], rho: rho[5:0], last: 1'b0};
          line_q.push_back(res);
          hits++;
        end
      end
      stamp_m[bin_idx] = ts;
    end
    if (hits == 0) line_q.push_back('{found: 1'b0, theta: '0, rho: '0, last: 1'b1});
    else line_q[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and result checking
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("event_hough_line_accumulator test failed");
    $finish;
  end

  // Results cannot be held off: every strobe is one transfer
  always @(posedge clk_i) begin
    line_res_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (line_q.size() == 0) begin
        $display("%0t unexpected line result found=%0d theta=%0d rho=%0d last=%0d",
                 $time, line_found_o, theta_bin_o, rho_bin_o, is_last_o);
        mismatch_cnt++;
      end else begin
        exp_r = line_q.pop_front();
        if (line_found_o !== exp_r.found) begin
          $display("%0t line_found expected %0d actual %0d", $time, exp_r.found,
                   line_found_o);
          mismatch_cnt++;
        end
        if (theta_bin_o !== exp_r.theta) begin
          $display("%0t theta_bin expected %0d actual %0d", $time, exp_r.theta,
                   theta_bin_o);
          mismatch_cnt++;
        end
        if (rho_bin_o !== exp_r.rho) begin
          $display("%0t rho_bin expected %0d actual %0d", $time, exp_r.rho, rho_bin_o);
          mismatch_cnt++;
        end
        if (is_last_o !== exp_r.last) begin
          $display("%0t is_last expected %0d actual %0d", $time, exp_r.last, is_last_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks; every task starts and ends just after a rising edge
  // ---------------------------------------------------------------------------

  // Register write, mirrored into the predictor's config
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_THRESHOLD:  cfg_m.threshold  = data;
      REG_TRACKING:   cfg_m.tracking   = data[0];
      REG_ZONE_THETA: cfg_m.zone_theta = data[2:0];
      REG_ZONE_RHO:   cfg_m.zone_rho   = data[2:0];
      REG_CENTER_X:   cfg_m.center_x   = data[9:0];
      REG_CENTER_Y:   cfg_m.center_y   = data[9:0];
      REG_RHO_SCALE:  cfg_m.rho_scale  = data;
      default: ;
    endcase
  endtask

  // One event transfer. start stays high after a transfer with no gap, so
  // back-to-back events see no bubble; the caller drains before going idle.
  task automatic send_event(bit [9:0] px, bit [9:0] py, bit [31:0] ts);
    int unsigned gap;
    start_i      <= 1'b1;
    pixel_x_i    <= px;
    pixel_y_i    <= py;
    event_time_i <= ts;
    do @(posedge clk_i); while (busy_o);
    vote_event(px, py, ts);
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every line due has come out
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (line_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic bit [9:0] wrap10(int v);
    return v[9:0];
  endfunction

  // Random stream: mostly short runs of points along a line close in time,
  // plus repeated pixels, lone noise events and rare long jumps in time
  task automatic random_events(int unsigned n_items);
    int unsigned sent, kind, len;
    int x0, y0, sx, sy;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) now_t += $urandom;
      if (kind < 65) begin
        x0  = int'(cfg_m.center_x) + $urandom_range(0, 400) - 200;
        y0  = int'(cfg_m.center_y) + $urandom_range(0, 400) - 200;
        sx  = $urandom_range(0, 6) - 3;
        sy  = $urandom_range(0, 6) - 3;
        len = $urandom_range(6, 16);
        for (int i = 0; i < len; i++) begin
          now_t += $urandom_range(0, 20);
          send_event(wrap10(x0 + i * sx + $urandom_range(0, 1)),
                     wrap10(y0 + i * sy + $urandom_range(0, 1)), now_t);
        end
      end else if (kind < 80) begin
        x0  = $urandom_range(0, 1023);
        y0  = $urandom_range(0, 1023);
        len = $urandom_range(3, 12);
        for (int i = 0; i < len; i++) begin
          now_t += $urandom_range(0, 3);
          send_event(x0[9:0], y0[9:0], now_t);
        end
      end else begin
        len = 1;
        now_t += $urandom_range(0, 5000);
        send_event(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), now_t);
      end
      sent += len;
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, a plain detection, long gap, time going back, wrap of the
  // time stamp, zero threshold and a zero rho scale
  task automatic test_directed();
    gap_pct = 0;
    send_event(10'd0, 10'd0, 32'd0);
    send_event(10'd1023, 10'd1023, 32'd1);
    send_event(10'd1023, 10'd0, 32'd2);
    send_event(10'd0, 10'd1023, 32'd3);
    send_event(10'd152, 10'd120, 32'd4);           // at the center: no vote
    for (int i = 0; i < 11; i++) send_event(10'd300, 10'd200, 32'd10 + i);
    send_event(10'd300, 10'd200, 32'h7FFF_FFFF);   // long gap decays to zero
    send_event(10'd300, 10'd200, 32'h7FFF_0000);   // time going back
    send_event(10'd300, 10'd200, 32'hFFFF_FFFF);
    send_event(10'd300, 10'd200, 32'h0000_0005);   // stamp wraps around
    drain();
    write_reg(REG_THRESHOLD, 16'd0);               // every voted bin detects
    send_event(10'd200, 10'd150, 32'd6);
    send_event(10'd40, 10'd900, 32'd7);
    drain();
    write_reg(REG_RHO_SCALE, 16'd0);               // nothing ever votes
    send_event(10'd700, 10'd20, 32'd8);
    drain();
    write_reg(REG_THRESHOLD, 16'd2560);
    write_reg(REG_RHO_SCALE, 16'd13107);
    now_t = 32'd100;
  endtask

  task automatic test_defaults_back_to_back();
    gap_pct = 0;
    random_events(40);
  endtask

  task automatic test_wide_zone_sender_idle();
    write_reg(REG_THRESHOLD, 16'd768);
    write_reg(REG_TRACKING, 16'd1);
    write_reg(REG_ZONE_THETA, 16'd7);
    write_reg(REG_ZONE_RHO, 16'd7);
    gap_pct = 48;
    random_events(50);
  endtask

  // Point zone, center at a corner: results cannot stall, so no idling here
  task automatic test_point_zone_corner_center();
    write_reg(REG_THRESHOLD, 16'd1024);
    write_reg(REG_ZONE_THETA, 16'd0);
    write_reg(REG_ZONE_RHO, 16'd0);
    write_reg(REG_CENTER_X, 16'd0);
    write_reg(REG_CENTER_Y, 16'd1023);
    write_reg(REG_RHO_SCALE, 16'd65535);
    gap_pct = 0;
    random_events(40);
  endtask

  task automatic test_zero_threshold_both_idle();
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_TRACKING, 16'd0);
    write_reg(REG_CENTER_X, 16'd1023);
    write_reg(REG_CENTER_Y, 16'd0);
    write_reg(REG_RHO_SCALE, 16'd30000);
    gap_pct = 37;
    random_events(30);
    write_reg(REG_THRESHOLD, 16'd1536);
    write_reg(REG_TRACKING, 16'd1);
    write_reg(REG_ZONE_THETA, 16'd3);
    write_reg(REG_ZONE_RHO, 16'd2);
    write_reg(REG_CENTER_X, 16'd512);
    write_reg(REG_CENTER_Y, 16'd512);
    write_reg(REG_RHO_SCALE, 16'd9000);
    random_events(30);
  endtask

  // Top threshold: a bin only detects once it saturates, after 256 votes
  task automatic test_saturation();
    write_reg(REG_THRESHOLD, 16'd65535);
    write_reg(REG_TRACKING, 16'd0);
    write_reg(REG_CENTER_X, 16'd152);
    write_reg(REG_CENTER_Y, 16'd120);
    write_reg(REG_RHO_SCALE, 16'd13107);
    gap_pct = 0;
    now_t += 32'd40000;
    for (int i = 0; i < 260; i++) send_event(10'd300, 10'd200, now_t);
    drain();
  endtask

  initial begin
    cfg_m = CFG_RESET;
    foreach (acc_m[i]) begin
      acc_m[i]   = '0;
      stamp_m[i] = '0;
    end
    build_tables();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_defaults_back_to_back();
    test_wide_zone_sender_idle();
    test_point_zone_corner_center();
    test_zero_threshold_both_idle();
    test_saturation();

    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0 && line_q.size() == 0) begin
      $display("event_hough_line_accumulator test passed");
    end else begin
      $display("event_hough_line_accumulator test failed");
    end
    $finish;
  end

endmodule
